FILE: design/ntprc_pkg.sv
// ----------------------------------------------------------------------------
// ntprc_pkg: shared types and constants
// Payload structs, status codes and the decimal digit tables used by the
// fraction-to-nanosecond conversion.
// ----------------------------------------------------------------------------
package ntprc_pkg;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSYNC  = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;

  localparam logic [1:0]  LEAP_ALARM   = 2'd3;
  localparam logic [2:0]  VERSION_MAX  = 3'd3;
  localparam logic [31:0] EPOCH_RESET  = 32'd2208988800;
  localparam logic [31:0] HIGH_BITS    = 32'hF000_0000;
  localparam logic [31:0] DIGIT_FACTOR = 32'h8AC7_2305;  // 2328306437 = ceil(10^19 / 2^32)

  // prescaled fraction is below 2^29 in both paths
  localparam int unsigned FRAC_W = 29;

  // Decimal digits of DIGIT_FACTOR, most significant first. Term k is
  // floor(f * DIGIT[k] / 10^(k+1)). The tenth term (digit 7 over 10^10) is
  // always zero for any f below 2^29, so it is not built.
  localparam int unsigned NUM_TERMS = 9;
  localparam logic [3:0] DIGIT [NUM_TERMS] = '{4'd2, 4'd3, 4'd2, 4'd8, 4'd3,
                                              4'd0, 4'd6, 4'd4, 4'd3};
  localparam longint unsigned POW10 [NUM_TERMS] = '{
    64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000};

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [31:0] tx_seconds;
    logic [31:0] tx_fraction;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] unix_seconds;
    logic [29:0] nanoseconds;
  } out_t;

  // header check result handed to the digit stage
  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       unix_seconds;
    logic              scaled;
    logic [FRAC_W-1:0] frac_f;
  } chk_t;

endpackage

FILE: design/ntprc_chan_if.sv
// ----------------------------------------------------------------------------
// ntprc_chan_if: valid/ready channel
// Generic handshake channel; one transaction per edge with valid and ready.
// ----------------------------------------------------------------------------
interface ntprc_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/ntprc_cdiv.sv
// ----------------------------------------------------------------------------
// ntprc_cdiv: divide by a constant
// Exact floor(x / DIVISOR) for 32-bit x via a 33-bit reciprocal multiply.
// ----------------------------------------------------------------------------
module ntprc_cdiv #(
  parameter longint unsigned DIVISOR = 10
) (
  input  logic [31:0] x,
  output logic [31:0] q
);

  localparam int unsigned SHIFT   = 32 + $clog2(DIVISOR);
  localparam logic [63:0] MAGIC64 = ((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR;
  localparam logic [32:0] MAGIC   = MAGIC64[32:0];

  logic [64:0] prod;
  logic [64:0] shifted;

  assign prod    = {33'd0, x} * {32'd0, MAGIC};
  assign shifted = prod >> SHIFT;
  assign q       = shifted[31:0];

endmodule

FILE: design/ntprc_check.sv
// ----------------------------------------------------------------------------
// ntprc_check: header check and fraction prescale
// Leap/seconds and version checks, Unix seconds, divide-by-ten prescale.
// ----------------------------------------------------------------------------
module ntprc_check (
  input  ntprc_pkg::in_t  item,
  input  logic [31:0]     epoch_offset,
  output ntprc_pkg::chk_t chk
);
  import ntprc_pkg::*;

  logic [1:0]  leap;
  logic [2:0]  version;
  logic        unsync;
  logic        bad_ver;
  logic [31:0] frac_div10;

  assign leap    = item.header_byte[7:6];
  assign version = item.header_byte[5:3];
  assign unsync  = (leap == LEAP_ALARM) || (item.tx_seconds == 32'd0);
  assign bad_ver = (version == 3'd0) || (version > VERSION_MAX);

  ntprc_cdiv #(.DIVISOR(10)) u_div10 (
    .x (item.tx_fraction),
    .q (frac_div10)
  );

  always_comb begin
    priority if (unsync) begin
      chk.status = ST_UNSYNC;
    end else if (bad_ver) begin
      chk.status = ST_VERSION;
    end else begin
      chk.status = ST_OK;
    end
    chk.unix_seconds = (chk.status == ST_OK) ? (item.tx_seconds - epoch_offset) : 32'd0;
    chk.scaled       = (item.tx_fraction & HIGH_BITS) != 32'd0;
    chk.frac_f       = chk.scaled ? frac_div10[FRAC_W-1:0] : item.tx_fraction[FRAC_W-1:0];
  end

endmodule

FILE: design/ntprc_terms.sv
// ----------------------------------------------------------------------------
// ntprc_terms: decimal digit terms
// One lane per digit: f * digit, then truncating divide by 10^(k+1).
// ----------------------------------------------------------------------------
module ntprc_terms (
  input  logic [ntprc_pkg::FRAC_W-1:0] frac_f,
  output logic [31:0]                  term [ntprc_pkg::NUM_TERMS]
);
  import ntprc_pkg::*;

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_lane
    if (DIGIT[k] == 4'd0) begin : g_zero
      assign term[k] = 32'd0;
    end else begin : g_div
      logic [31:0] scaled_f;
      // below 2^32: f < 2^29 and digit <= 8
      assign scaled_f = {{(32-FRAC_W){1'b0}}, frac_f} * {28'd0, DIGIT[k]};
      ntprc_cdiv #(.DIVISOR(POW10[k])) u_div (
        .x (scaled_f),
        .q (term[k])
      );
    end
  end

endmodule

FILE: design/ntp_reply_timestamp_check_convert.sv
// ----------------------------------------------------------------------------
// ntp_reply_timestamp_check_convert: SNTP reply check and timespec conversion
// Validates an SNTP reply header and turns its transmit timestamp into Unix
// seconds and nanoseconds.
// ----------------------------------------------------------------------------
// One result transaction per input transaction; one transaction per cycle
// sustained while out_chan.ready stays high. The path is a four
// register pipeline: input register, header check with divide-by-ten
// prescale, nine parallel digit lanes (constant multiply plus reciprocal
// divide), then the digit sum and the output register. Each stage has its own
// valid bit and moves when it is empty or the next stage moves, so bubbles
// collapse while a result waits at the output. Status 1 (unsynchronized: leap
// indicator 3 or zero seconds) wins over status 2 (version 0 or above 3);
// rejected replies carry zero seconds and nanoseconds. cfg_chan is always
// ready and loads epoch_offset (reset 2208988800); write it only while idle.
// ----------------------------------------------------------------------------
module ntp_reply_timestamp_check_convert (
  input  logic         clk,
  input  logic         rst_n,
  ntprc_chan_if.sink   in_chan,
  ntprc_chan_if.source out_chan,
  ntprc_chan_if.sink   cfg_chan
);
  import ntprc_pkg::*;

  // stage valids and per-stage advance enables
  logic a_v_r, b_v_r, c_v_r, o_v_r;
  logic en_a, en_b, en_c, en_o;

  logic [31:0] epoch_r;

  in_t         a_data_r;
  chk_t        chk_nxt, chk_r;
  chk_t        c_chk_r;
  logic [31:0] term_nxt [NUM_TERMS];
  logic [31:0] term_r   [NUM_TERMS];
  out_t        out_nxt, out_r;

  logic [33:0] sum;
  logic [33:0] sum_x10;

  assign en_o = !o_v_r || out_chan.ready;
  assign en_c = !c_v_r || en_o;
  assign en_b = !b_v_r || en_c;
  assign en_a = !a_v_r || en_b;

  assign in_chan.ready  = en_a;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = o_v_r;
  assign out_chan.data  = out_r;

  // epoch register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_RESET;
    end else if (cfg_chan.valid) begin
      epoch_r <= cfg_chan.data;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= in_chan.valid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
      if (en_o) o_v_r <= c_v_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en_a) a_data_r <= in_chan.data;
    if (en_b) chk_r    <= chk_nxt;
    if (en_c) begin
      c_chk_r <= chk_r;
      term_r  <= term_nxt;
    end
    if (en_o) out_r <= out_nxt;
  end

  // stage 1: header checks, seconds, prescale
  ntprc_check u_check (
    .item         (a_data_r),
    .epoch_offset (epoch_r),
    .chk          (chk_nxt)
  );

  // stage 2: digit lanes
  ntprc_terms u_terms (
    .frac_f (chk_r.frac_f),
    .term   (term_nxt)
  );

  // stage 3: digit sum, undo prescale, assemble result
  always_comb begin
    sum = 34'd0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      sum = sum + {2'b00, term_r[k]};
    end
    sum_x10 = (sum << 3) + (sum << 1);

    out_nxt.status       = c_chk_r.status;
    out_nxt.unix_seconds = c_chk_r.unix_seconds;
    if (c_chk_r.status != ST_OK) begin
      out_nxt.nanoseconds = 30'd0;
    end else if (c_chk_r.scaled) begin
      out_nxt.nanoseconds = sum_x10[29:0];
    end else begin
      out_nxt.nanoseconds = sum[29:0];
    end
  end

  // checks
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && out_r.status != ST_OK) |->
      (out_r.unix_seconds == 32'd0 && out_r.nanoseconds == 30'd0))
    else $error("rejected result carries nonzero time");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> (out_r.status == ST_OK || out_r.status == ST_UNSYNC ||
               out_r.status == ST_VERSION))
    else $error("illegal status code");

  a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> (out_r.nanoseconds < 30'd1000000000))
    else $error("nanoseconds out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (a_v_r && b_v_r && c_v_r && o_v_r && !out_chan.ready))
    else $error("input stalled with room in the pipeline");

endmodule

FILE: bench/tb_ntp_reply_timestamp_check_convert.sv
// ----------------------------------------------------------------------------
// tb_ntp_reply_timestamp_check_convert: self-checking bench for the SNTP reply
// check and timespec conversion block.
// Drives reply headers and transmit timestamps through the input channel and
// predicts status, Unix seconds and nanoseconds for every transaction. Each
// result is checked in order against the oldest prediction. The epoch offset
// is reprogrammed between phases, and both channels see random gaps and
// stalls. Repeated long output stalls back up the pipeline.
// ----------------------------------------------------------------------------
module tb_ntp_reply_timestamp_check_convert;
  import ntprc_pkg::*;

  // allow some slack after draining
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 260;

  logic clk;
  logic rst_n;

  ntprc_chan_if #(.T(in_t))         in_chan ();
  ntprc_chan_if #(.T(out_t))        out_chan ();
  ntprc_chan_if #(.T(logic [31:0])) cfg_chan ();

  ntp_reply_timestamp_check_convert i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Replies waiting to be driven, and the predicted results of the replies
  // that the block has accepted.
  in_t         pending_replies[$];
  out_t        expected_results[$];
  logic [31:0] epoch_now;       // bench copy of the epoch offset register
  int unsigned error_count;
  int unsigned results_seen;
  bit          no_idle;         // set for phases that run back to back
  bit          in_took;         // input transaction at the last rising edge
  bit          out_took;        // output transaction at the last rising edge

  // sender and receiver pacing
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_left;
  int unsigned next_hold_at;

  // per-edge scratch
  logic next_valid;
  in_t  next_item;
  logic next_ready;
  out_t want;
  out_t got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Truncating ten-digit decimal sum: the fraction times each decimal digit of
  // DIGIT_FACTOR, term k divided by 10^(k+1). Fractions with any of the top
  // four bits set are divided by ten first and the sum is scaled back at the
  // end, so the low digit of those results is always zero.
  function automatic logic [29:0] frac_to_nanoseconds(logic [31:0] frac);
    longint unsigned f;
    longint unsigned rest;
    longint unsigned place;
    longint unsigned divisor;
    longint unsigned total;
    bit              prescaled;
    prescaled = (frac & HIGH_BITS) != 32'd0;
    f         = prescaled ? frac / 10 : frac;
    rest      = DIGIT_FACTOR;
    place     = 64'd1000000000;
    divisor   = 64'd10;
    total     = 0;
    for (int k = 0; k < 10; k++) begin
      total   += (f * (rest / place)) / divisor;
      rest     = rest % place;
      place    = (place > 1) ? place / 10 : 64'd1;
      divisor *= 10;
    end
    if (prescaled) total *= 10;
    return total[29:0];
  endfunction

  // Unsynchronized (leap alarm or zero seconds) wins over a bad version.
  // Rejected replies carry zero seconds and nanoseconds.
  function automatic out_t convert_reply(in_t item, logic [31:0] epoch);
    out_t       r;
    logic [1:0] leap;
    logic [2:0] ver;
    r    = '0;
    leap = item.header_byte[7:6];
    ver  = item.header_byte[5:3];
    if (leap == LEAP_ALARM || item.tx_seconds == 32'd0) begin
      r.status = ST_UNSYNC;
    end else if (ver == 3'd0 || ver > VERSION_MAX) begin
      r.status = ST_VERSION;
    end else begin
      r.status       = ST_OK;
      r.unix_seconds = item.tx_seconds - epoch;
      r.nanoseconds  = frac_to_nanoseconds(item.tx_fraction);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_t make_reply(logic [1:0] leap, logic [2:0] ver, logic [2:0] mode,
                                     logic [31:0] secs, logic [31:0] frac);
    in_t item;
    item.header_byte = {leap, ver, mode};
    item.tx_seconds  = secs;
    item.tx_fraction = frac;
    return item;
  endfunction

  // Mostly well-formed replies with random content; the rest is random
  // headers, a share of them with zero seconds.
  function automatic in_t rand_reply();
    in_t         item;
    int unsigned roll;
    logic [1:0]  leap;
    logic [2:0]  ver;
    logic [2:0]  mode;
    logic [31:0] frac;
    roll = $urandom_range(99);
    frac = $urandom();
    // a quarter of the fractions stay below 2^28 and skip the prescale
    if ($urandom_range(3) == 0) frac[31:28] = 4'h0;
    leap = 2'($urandom_range(2));
    ver  = 3'($urandom_range(3, 1));
    mode = 3'($urandom_range(7));
    item = make_reply(leap, ver, mode, $urandom(), frac);
    if (roll < 75) begin
      if (item.tx_seconds == 32'd0) item.tx_seconds = 32'd1;
    end else begin
      item.header_byte = 8'($urandom_range(255));
      if (roll < 85) item.tx_seconds = 32'd0;
    end
    return item;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (no_idle || roll < 45) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 12);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: inputs change at the falling edge. Valid is held until the
  // transaction completes, then dropped for the chosen gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    next_valid = in_chan.valid;
    next_item  = in_chan.data;
    if (!in_chan.valid || in_took) begin
      next_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_replies.size() != 0) begin
        next_item  = pending_replies.pop_front();
        next_valid = 1'b1;
        tx_gap     = pick_gap();
      end
    end
    in_chan.valid <= next_valid;
    in_chan.data  <= next_item;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off every few hundred results
  // while the sender keeps offering, so the pipeline fills and in_chan.ready
  // drops.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      next_ready = 1'b0;
      hold_left--;
    end else if (results_seen >= next_hold_at) begin
      next_ready    = 1'b0;
      hold_left     = $urandom_range(120, 60);
      next_hold_at += 450;
    end else if (rx_gap > 0) begin
      next_ready = 1'b0;
      rx_gap--;
    end else begin
      rx_gap     = out_took ? pick_gap() : 0;
      next_ready = (rx_gap == 0);
      if (rx_gap > 0) rx_gap--;
    end
    out_chan.ready <= next_ready;
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Predictions are made at
  // input accept with the epoch offset in force at that point; register
  // writes only happen while the block is empty.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready) begin
      results_seen++;
      got = out_chan.data;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transaction: status %0d sec %0d ns %0d",
                 $time, got.status, got.unix_seconds, got.nanoseconds);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.unix_seconds !== want.unix_seconds ||
            got.nanoseconds !== want.nanoseconds) begin
          error_count++;
          $display("%0t: mismatch: exp st %0d sec %0d ns %0d, got st %0d sec %0d ns %0d",
                   $time, want.status, want.unix_seconds, want.nanoseconds,
                   got.status, got.unix_seconds, got.nanoseconds);
        end
      end
    end
    if (in_chan.valid && in_chan.ready)
      expected_results.push_back(convert_reply(in_chan.data, epoch_now));
    if (cfg_chan.valid && cfg_chan.ready)
      epoch_now = cfg_chan.data;
    in_took  <= in_chan.valid && in_chan.ready;
    out_took <= out_chan.valid && out_chan.ready;
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Wait until every reply has gone through and no prediction is open, then
  // let the pipeline settle.
  task automatic wait_drained();
    while (pending_replies.size() != 0 || in_chan.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_epoch(input logic [31:0] value);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic run_phase(input bit back_to_back);
    @(posedge clk);
    no_idle = back_to_back;
    repeat (PHASE_ITEMS) pending_replies.push_back(rand_reply());
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    epoch_now      = EPOCH_RESET;
    error_count    = 0;
    results_seen   = 0;
    no_idle        = 1'b0;
    in_took        = 1'b0;
    out_took       = 1'b0;
    tx_gap         = 0;
    rx_gap         = 0;
    hold_left      = 0;
    next_hold_at   = 200;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed replies at the reset epoch offset.
    // leap alarm with bad and good versions, zero and nonzero seconds: unsynchronized wins
    pending_replies.push_back(make_reply(2'd3, 3'd0, 3'd0, 32'd0, 32'd0));
    pending_replies.push_back(make_reply(2'd3, 3'd4, 3'd3, EPOCH_RESET + 1, 32'hFFFF_FFFF));
    pending_replies.push_back(make_reply(2'd3, 3'd7, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_replies.push_back(make_reply(2'd3, 3'd3, 3'd4, 32'hE000_0000, 32'h1234_5678));
    // zero seconds, with a good and with a bad version
    pending_replies.push_back(make_reply(2'd1, 3'd3, 3'd4, 32'd0, 32'h8000_0000));
    pending_replies.push_back(make_reply(2'd0, 3'd4, 3'd4, 32'd0, 32'h1234_5678));
    // unsupported versions
    pending_replies.push_back(make_reply(2'd0, 3'd0, 3'd0, 32'hE000_0000, 32'h0));
    pending_replies.push_back(make_reply(2'd0, 3'd4, 3'd4, 32'hE000_0000, 32'hFFFF_FFFF));
    pending_replies.push_back(make_reply(2'd1, 3'd5, 3'd1, 32'h0000_0001, 32'h0FFF_FFFF));
    pending_replies.push_back(make_reply(2'd2, 3'd6, 3'd2, 32'h7FFF_FFFF, 32'h1000_0000));
    pending_replies.push_back(make_reply(2'd2, 3'd7, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // good replies: seconds below the epoch wrap, extremes of the fraction,
    // both sides of the prescale boundary
    pending_replies.push_back(make_reply(2'd0, 3'd1, 3'd3, 32'd1, 32'd0));
    pending_replies.push_back(make_reply(2'd0, 3'd2, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_replies.push_back(make_reply(2'd0, 3'd3, 3'd4, EPOCH_RESET, 32'h0FFF_FFFF));
    pending_replies.push_back(make_reply(2'd1, 3'd3, 3'd4, EPOCH_RESET + 1, 32'h1000_0000));
    pending_replies.push_back(make_reply(2'd2, 3'd3, 3'd0, 32'hE123_4567, 32'h8000_0000));
    pending_replies.push_back(make_reply(2'd0, 3'd3, 3'd7, 32'h7FFF_FFFF, 32'd1));
    pending_replies.push_back(make_reply(2'd0, 3'd1, 3'd0, 32'h8000_0000, 32'hFFFF_FFFE));
    pending_replies.push_back(make_reply(2'd2, 3'd2, 3'd5, 32'hDEAD_BEEF, 32'h0000_FFFF));
    pending_replies.push_back(make_reply(2'd1, 3'd2, 3'd6, 32'h5555_5555, 32'hAAAA_AAAA));
    wait_drained();

    // random phases across several epoch settings, extremes included
    run_phase(1'b0);
    write_epoch(32'd0);
    run_phase(1'b0);
    write_epoch(32'hFFFF_FFFF);
    run_phase(1'b1);
    write_epoch(EPOCH_RESET);
    run_phase(1'b0);
    write_epoch($urandom());
    run_phase(1'b0);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: a few times the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
design/ntprc_pkg.sv
design/ntprc_chan_if.sv
design/ntprc_cdiv.sv
design/ntprc_check.sv
design/ntprc_terms.sv
design/ntp_reply_timestamp_check_convert.sv
bench/tb_ntp_reply_timestamp_check_convert.sv
